@@ hw/rtl/remote_control_frame_decoder_assert.svh @@
// Assertion macros for the remote control frame decoder.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef REMOTE_CONTROL_FRAME_DECODER_ASSERT_SVH
`define REMOTE_CONTROL_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rcfd_pkg.sv @@
// Shared constants, types and stick helper for the remote control frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package rcfd_pkg;

    localparam int FRAME_LEN        = 18;
    localparam int FIDX_W           = 5;
    localparam int BUFFER_BYTES_DEF = 36;
    localparam int CH_W             = 11;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 11;
    localparam int OUT_TDATA_W      = 144;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE   = 2'd2;

    localparam logic [CH_W-1:0] OFFSET_RST = 11'd1024;
    localparam logic [CH_W-1:0] LIMIT_RST  = 11'd700;
    localparam logic [1:0]      SAFE_RST   = 2'd2;

    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    typedef struct packed {
        logic            over;
        logic [CH_W-1:0] val;
    } t_stick_eval;

    // Remove the offset, flag an oversize magnitude, clamp to 11 bits signed.
    function automatic t_stick_eval f_eval_stick(input logic [CH_W-1:0] raw,
                                                 input logic [CH_W-1:0] off,
                                                 input logic [CH_W-1:0] limit);
        logic signed [CH_W:0] d;
        logic [CH_W:0]        mag;
        t_stick_eval          r;
        d   = $signed({1'b0, raw}) - $signed({1'b0, off});
        mag = d[CH_W] ? 12'(-d) : 12'(d);
        r.over = (mag > {1'b0, limit});
        if (d > 12'sd1023) begin
            r.val = 11'h3ff;
        end else if (d < -12'sd1024) begin
            r.val = 11'h400;
        end else begin
            r.val = d[CH_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/remote_control_frame_decoder.sv @@
// Remote control frame decoder: byte buffer, frame unpack/check and held record.
// Depends on rcfd_pkg and remote_control_frame_decoder_assert.svh.
//
//   channel   dir  beat content
//   -------   ---  ----------------------------------------------------------
//   s_axis    in   tuser = kind (1 = line idle), tdata = rx_byte
//   m_axis    out  tuser = status, tdata = sticks, aux, switches, mouse, keys
//   cfg       in   i_cfg_index selects register, i_cfg_data is the value
//
// An input beat can be taken in every cycle while s_axis_tready is high.
// An idle beat decodes the buffered frame in that cycle straight into the
// held record, which doubles as the output register; one result per idle.
// s_axis_tready drops only while a result waits and m_axis_tready is low.
// Reset (i_rst_n low, synchronous) clears count, held record and valid, and loads config reset values.
// The configuration port is always ready.
`timescale 1ns / 1ps
`include "remote_control_frame_decoder_assert.svh"

module remote_control_frame_decoder
    import rcfd_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    input  logic                   s_axis_tuser,   // [0] kind
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [10:0] stick_0, [21:11] stick_1, [32:22] stick_2, [43:33] stick_3,
    // [59:44] aux_channel, [63:60] switches, [79:64] mouse_x, [95:80] mouse_y,
    // [111:96] mouse_z, [127:112] buttons, [143:128] keys
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,   // [1:0] status
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // configuration
    logic [CH_W-1:0] r_offset;
    logic [CH_W-1:0] r_limit;
    logic [1:0]      r_safe;

    // frame buffer and byte count
    logic [7:0]       r_frame [FRAME_LEN];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // held record, shown on m_axis
    logic                   r_out_valid;
    logic [1:0]             r_status;
    logic [CH_W-1:0]        r_stick [4];
    logic [15:0]            r_aux;
    logic [3:0]             r_switches;
    logic [15:0]            r_mouse_x;
    logic [15:0]            r_mouse_y;
    logic [15:0]            r_mouse_z;
    logic [15:0]            r_buttons;
    logic [15:0]            r_keys;

    logic                   n_out_valid;
    logic [1:0]             n_status;
    logic [CH_W-1:0]        n_stick [4];
    logic [15:0]            n_aux;
    logic [3:0]             n_switches;
    logic [15:0]            n_mouse_x;
    logic [15:0]            n_mouse_y;
    logic [15:0]            n_mouse_z;
    logic [15:0]            n_buttons;
    logic [15:0]            n_keys;

    logic            in_beat;
    logic            byte_beat;
    logic            idle_beat;
    logic            store_byte;
    logic [CH_W-1:0] raw [4];
    t_stick_eval     eval [4];
    logic [1:0]      sw_left;
    logic [1:0]      sw_right;
    logic            frame_bad;
    logic            len_ok;

    // Stall input only while a result is stuck at the output.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign byte_beat     = in_beat && !s_axis_tuser;
    assign idle_beat     = in_beat && s_axis_tuser;
    assign store_byte    = byte_beat && (r_count < CNT_FRAME);
    assign len_ok        = (r_count == CNT_FRAME);
    assign o_cfg_ready   = 1'b1;

    // Unpack the four 11-bit channels packed LSB first across bytes 0..5.
    assign raw[0]   = {r_frame[1][2:0], r_frame[0]};
    assign raw[1]   = {r_frame[2][5:0], r_frame[1][7:3]};
    assign raw[2]   = {r_frame[4][0], r_frame[3], r_frame[2][7:6]};
    assign raw[3]   = {r_frame[5][3:0], r_frame[4][7:1]};
    assign sw_left  = r_frame[5][5:4];
    assign sw_right = r_frame[5][7:6];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            eval[k] = f_eval_stick(raw[k], r_offset, r_limit);
        end
    end

    assign frame_bad = eval[0].over || eval[1].over || eval[2].over || eval[3].over ||
                       (sw_left == 2'd0) || (sw_right == 2'd0);

    // Count saturates; an idle beat restarts the frame.
    always_comb begin
        n_count = r_count;
        if (idle_beat) begin
            n_count = '0;
        end else if (byte_beat && (r_count != CNT_MAX)) begin
            n_count = r_count + CNT_ONE;
        end
    end

    // Next held record: replace on a good-length frame, else keep it with status set to hold.
    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_status    = r_status;
        n_stick     = r_stick;
        n_aux       = r_aux;
        n_switches  = r_switches;
        n_mouse_x   = r_mouse_x;
        n_mouse_y   = r_mouse_y;
        n_mouse_z   = r_mouse_z;
        n_buttons   = r_buttons;
        n_keys      = r_keys;
        if (idle_beat) begin
            n_out_valid = 1'b1;
            if (!len_ok) begin
                n_status = ST_HOLD;
            end else if (frame_bad) begin
                // failed check: zero everything, force switches to safe code
                n_status   = ST_FAIL;
                for (int k = 0; k < 4; k++) begin
                    n_stick[k] = '0;
                end
                n_aux      = '0;
                n_switches = {r_safe, r_safe};
                n_mouse_x  = '0;
                n_mouse_y  = '0;
                n_mouse_z  = '0;
                n_buttons  = '0;
                n_keys     = '0;
            end else begin
                n_status   = ST_GOOD;
                for (int k = 0; k < 4; k++) begin
                    n_stick[k] = eval[k].val;
                end
                n_aux      = {r_frame[17], r_frame[16]} - {5'd0, r_offset};
                n_switches = {sw_right, sw_left};
                n_mouse_x  = {r_frame[7], r_frame[6]};
                n_mouse_y  = {r_frame[9], r_frame[8]};
                n_mouse_z  = {r_frame[11], r_frame[10]};
                n_buttons  = {r_frame[13], r_frame[12]};
                n_keys     = {r_frame[15], r_frame[14]};
            end
        end
    end

    // Frame buffer: payload only, no reset.
    always_ff @(posedge i_clk) begin
        if (store_byte) begin
            r_frame[r_count[FIDX_W-1:0]] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= OFFSET_RST;
            r_limit     <= LIMIT_RST;
            r_safe      <= SAFE_RST;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_GOOD;
            for (int k = 0; k < 4; k++) begin
                r_stick[k] <= '0;
            end
            r_aux       <= '0;
            r_switches  <= '0;
            r_mouse_x   <= '0;
            r_mouse_y   <= '0;
            r_mouse_z   <= '0;
            r_buttons   <= '0;
            r_keys      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OFFSET: r_offset <= i_cfg_data;
                    CFG_LIMIT:  r_limit  <= i_cfg_data;
                    CFG_SAFE:   r_safe   <= i_cfg_data[1:0];
                    default:    ;
                endcase
            end
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_stick     <= n_stick;
            r_aux       <= n_aux;
            r_switches  <= n_switches;
            r_mouse_x   <= n_mouse_x;
            r_mouse_y   <= n_mouse_y;
            r_mouse_z   <= n_mouse_z;
            r_buttons   <= n_buttons;
            r_keys      <= n_keys;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {r_keys, r_buttons, r_mouse_z, r_mouse_y, r_mouse_x,
                            r_switches, r_aux, r_stick[3], r_stick[2], r_stick[1],
                            r_stick[0]};

    `RCFD_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_MAX, "byte count above buffer size")
    `RCFD_ASSERT_NEXT(a_idle_result, idle_beat, r_out_valid && (r_count == '0), "idle beat gave no result")
    `RCFD_ASSERT_NOW(a_fail_zeroed, r_out_valid && (r_status == ST_FAIL), (r_stick[0] == '0) && (r_mouse_x == '0) && (r_keys == '0), "failed frame not zeroed")
    `RCFD_ASSERT_NOW(a_stall_blocks, r_out_valid && !m_axis_tready, !s_axis_tready, "input taken over a stalled result")

endmodule

@@ sim/tb_remote_control_frame_decoder.sv @@
// Self-checking testbench for remote_control_frame_decoder: byte and line-idle beats in,
// one decoded control record out per idle beat, checked against an in-bench frame decoder.
// Depends on rcfd_pkg and the remote_control_frame_decoder RTL.
`timescale 1ns / 1ps

module tb_remote_control_frame_decoder
    import rcfd_pkg::*;
();

    localparam int N_ITEMS   = 1700;     // random beats, spread over five phases
    localparam int N_PHASES  = 5;
    localparam int LONG_HOLD = 300;      // receiver back-pressure stretch, in cycles

    // One decoded control record as it leaves the block, status included.
    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] stick_0;
        logic [10:0] stick_1;
        logic [10:0] stick_2;
        logic [10:0] stick_3;
        logic [15:0] aux;
        logic [3:0]  switches;
        logic [15:0] mouse_x;
        logic [15:0] mouse_y;
        logic [15:0] mouse_z;
        logic [15:0] buttons;
        logic [15:0] keys;
    } rc_record_t;

    // Directed frame: n_bytes data beats taken cyclically from payload, then an idle beat.
    typedef struct {
        int unsigned  n_bytes;
        logic [143:0] payload;
        bit           typed;
        rc_record_t   want;
    } frame_row_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Decoder copy: frame buffer, byte count, held record and register shadows.
    logic [7:0]  rx_buf [FRAME_LEN];
    logic [5:0]  rx_count   = '0;
    rc_record_t  held       = '0;
    logic [10:0] cur_offset = OFFSET_RST;
    logic [10:0] cur_limit  = LIMIT_RST;
    logic [1:0]  cur_safe   = SAFE_RST;

    rc_record_t  record_q [$];           // decoded records still owed by the block
    int          err_cnt   = 0;
    int          sent      = 0;
    bit          calm      = 1'b0;       // no gaps on either side while set
    bit          long_hold = 1'b0;       // receiver: request one LONG_HOLD hold-off

    // Frame payload bits: sticks at [43:0] (11 bits each), left switch [45:44],
    // right switch [47:46], mouse x/y/z, buttons, keys, raw fifth channel [143:128].
    frame_row_t frame_table [4] = '{
        // idle straight after reset: wrong length, all-zero held record
        '{0, '0, 1'b1, rc_record_t'{status: ST_HOLD, default: '0}},
        // centered sticks, both switches set, extreme mouse/button/key values
        '{18, {16'h0000, 16'hffff, 16'h00ff, 16'h0001, 16'h7fff, 16'h8000, 4'b1101,
               11'h400, 11'h400, 11'h400, 11'h400}, 1'b0, '0},
        // all ones: sticks far past the limit, so safe values replace the record
        '{18, {144{1'b1}}, 1'b1,
          rc_record_t'{status: ST_FAIL, switches: {SAFE_RST, SAFE_RST}, default: '0}},
        // long frame past the buffer size: count saturates, held record repeats
        '{40, '0, 1'b1,
          rc_record_t'{status: ST_HOLD, switches: {SAFE_RST, SAFE_RST}, default: '0}}
    };

    remote_control_frame_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 19));
        if (r < 14) return 0;
        if (r < 19) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // Raw channel value, mostly within the limit around the offset, sometimes right on
    // or just past the limit, sometimes anywhere.
    function automatic logic [10:0] pick_channel();
        int v;
        case ($urandom_range(0, 19))
            0:       v = int'($urandom_range(0, 2047));
            1:       v = int'(cur_offset) + int'(cur_limit);
            2:       v = int'(cur_offset) - int'(cur_limit);
            3:       v = int'(cur_offset) + int'(cur_limit) + 1;
            4:       v = int'(cur_offset) - int'(cur_limit) - 1;
            default: v = int'(cur_offset) + int'($urandom_range(0, 2 * cur_limit))
                         - int'(cur_limit);
        endcase
        if (v < 0) v = 0;
        if (v > 2047) v = 2047;
        return v[10:0];
    endfunction

    // Advance the decoder copy by one accepted beat. Returns 1 when the beat is an
    // idle, with the record the block must report in rec.
    function automatic bit decode_beat(input logic kind, input logic [7:0] rx,
                                       output rc_record_t rec);
        logic [143:0] fr;
        logic [10:0]  st [4];
        int           d;
        int           mag;
        bit           bad;
        rec = '0;
        if (!kind) begin
            // bytes past the frame length are dropped, the count saturates
            if (rx_count < FRAME_LEN) rx_buf[rx_count[4:0]] = rx;
            if (rx_count < BUFFER_BYTES_DEF) rx_count = rx_count + 6'd1;
            return 1'b0;
        end
        if (rx_count == FRAME_LEN) begin
            for (int i = 0; i < FRAME_LEN; i++) fr[8*i +: 8] = rx_buf[i];
            bad = (fr[45:44] == 2'd0) || (fr[47:46] == 2'd0);
            for (int k = 0; k < 4; k++) begin
                // the check sees the full difference, the stored value is clamped
                d   = int'(fr[11*k +: 11]) - int'(cur_offset);
                mag = (d < 0) ? -d : d;
                if (mag > int'(cur_limit)) bad = 1'b1;
                if (d > 1023) st[k] = 11'h3ff;
                else if (d < -1024) st[k] = 11'h400;
                else st[k] = d[10:0];
            end
            if (bad) begin
                held          = '0;
                held.switches = {cur_safe, cur_safe};
                held.status   = ST_FAIL;
            end else begin
                held.stick_0  = st[0];
                held.stick_1  = st[1];
                held.stick_2  = st[2];
                held.stick_3  = st[3];
                held.switches = fr[47:44];
                held.mouse_x  = fr[63:48];
                held.mouse_y  = fr[79:64];
                held.mouse_z  = fr[95:80];
                held.buttons  = fr[111:96];
                held.keys     = fr[127:112];
                held.aux      = fr[143:128] - {5'd0, cur_offset};
                held.status   = ST_GOOD;
            end
        end else begin
            held.status = ST_HOLD;
        end
        rx_count = '0;
        rec = held;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR: %s: got %h, expected %h", what, got, want);
        err_cnt++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Offer one beat on s_axis and wait for the handshake. A typed row overrides the
    // decoder copy's record, but the copy still advances.
    task automatic send_beat(input logic kind, input logic [7:0] rx, input bit typed,
                             input rc_record_t want);
        int         gap;
        rc_record_t rec;
        gap = calm ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= rx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (decode_beat(kind, rx, rec)) record_q.push_back(typed ? want : rec);
        sent++;
    endtask

    task automatic send_frame(input int unsigned n, input logic [143:0] fr, input bit typed,
                              input rc_record_t want);
        for (int unsigned i = 0; i < n; i++) send_beat(1'b0, fr[8*(i % 18) +: 8], 1'b0, want);
        // the byte on an idle beat is don't-care, so drive noise there
        send_beat(1'b1, 8'($urandom), typed, want);
    endtask

    // Drop valid, drain every owed record, then let the clock run on idle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (record_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_OFFSET: cur_offset = val;
            CFG_LIMIT:  cur_limit  = val;
            CFG_SAFE:   cur_safe   = val[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, or one long hold-off when asked.
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold = 1'b0;
            end else begin
                gap = calm ? 0 : pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    end

    // Result checker: compare each accepted record with the oldest one owed.
    always @(posedge i_clk) begin
        rc_record_t got;
        rc_record_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status   = m_axis_tuser;
            got.stick_0  = m_axis_tdata[10:0];
            got.stick_1  = m_axis_tdata[21:11];
            got.stick_2  = m_axis_tdata[32:22];
            got.stick_3  = m_axis_tdata[43:33];
            got.aux      = m_axis_tdata[59:44];
            got.switches = m_axis_tdata[63:60];
            got.mouse_x  = m_axis_tdata[79:64];
            got.mouse_y  = m_axis_tdata[95:80];
            got.mouse_z  = m_axis_tdata[111:96];
            got.buttons  = m_axis_tdata[127:112];
            got.keys     = m_axis_tdata[143:128];
            if (record_q.size() == 0) begin
                report_mismatch("result beat with nothing owed, status", 16'(got.status),
                                16'd0);
            end else begin
                want = record_q.pop_front();
                check_field("status",      16'(got.status),   16'(want.status));
                check_field("stick_0",     16'(got.stick_0),  16'(want.stick_0));
                check_field("stick_1",     16'(got.stick_1),  16'(want.stick_1));
                check_field("stick_2",     16'(got.stick_2),  16'(want.stick_2));
                check_field("stick_3",     16'(got.stick_3),  16'(want.stick_3));
                check_field("aux_channel", got.aux,           want.aux);
                check_field("switches",    16'(got.switches), 16'(want.switches));
                check_field("mouse_x",     got.mouse_x,       want.mouse_x);
                check_field("mouse_y",     got.mouse_y,       want.mouse_y);
                check_field("mouse_z",     got.mouse_z,       want.mouse_z);
                check_field("buttons",     got.buttons,       want.buttons);
                check_field("keys",        got.keys,          want.keys);
            end
        end
    end

    initial begin
        logic [143:0] fr;
        int unsigned  n;
        int           target;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (frame_table[r])
            send_frame(frame_table[r].n_bytes, frame_table[r].payload, frame_table[r].typed,
                       frame_table[r].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: begin
                        write_reg(CFG_OFFSET, 11'd0);
                        write_reg(CFG_LIMIT, 11'd1024);
                        write_reg(CFG_SAFE, 11'd3);
                    end
                    2: begin
                        write_reg(CFG_OFFSET, 11'd2047);
                        write_reg(CFG_LIMIT, 11'd0);
                        write_reg(CFG_SAFE, 11'd0);
                    end
                    3: begin
                        write_reg(CFG_OFFSET, 11'($urandom_range(0, 2047)));
                        write_reg(CFG_LIMIT, 11'($urandom_range(0, 1024)));
                        write_reg(CFG_SAFE, 11'd1);
                    end
                    default: begin
                        write_reg(CFG_OFFSET, OFFSET_RST);
                        write_reg(CFG_LIMIT, LIMIT_RST);
                        write_reg(CFG_SAFE, 11'(SAFE_RST));
                    end
                endcase
            end
            calm = (ph == 3);
            // hold the receiver off while the sender keeps offering: the block
            // must fill up and stall its input
            if (ph == 1) long_hold = 1'b1;
            target = sent + N_ITEMS / N_PHASES;
            while (sent < target) begin
                for (int i = 0; i < FRAME_LEN; i++) begin
                    case ($urandom_range(0, 9))
                        0:       fr[8*i +: 8] = 8'h00;
                        1:       fr[8*i +: 8] = 8'hff;
                        default: fr[8*i +: 8] = 8'($urandom);
                    endcase
                end
                // most frames get shaped sticks and switches, the rest stay noise
                if ($urandom_range(0, 9) != 0) begin
                    for (int k = 0; k < 4; k++) fr[11*k +: 11] = pick_channel();
                    fr[45:44] = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
                    fr[47:46] = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
                end
                case ($urandom_range(0, 9))
                    0:       n = $urandom_range(0, 17);
                    1:       n = $urandom_range(19, 45);
                    default: n = 18;
                endcase
                send_frame(n, fr, 1'b0, '0);
            end
        end

        drain();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rcfd_pkg.sv
hw/rtl/remote_control_frame_decoder.sv
sim/tb_remote_control_frame_decoder.sv
